>>> design/nmea_gll_sentence_framer_top_defines.svh
// Assertion macros used by the checker file of the sentence framer.
`ifndef NMEA_GLL_SENTENCE_FRAMER_TOP_DEFINES_SVH
`define NMEA_GLL_SENTENCE_FRAMER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NGSF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NGSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ngsf_pkg.sv
package ngsf_pkg;

    // Characters that steer framing.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_L      = 8'h4C;

    // Position of the byte that must be 'L' for a GLL sentence.
    localparam int unsigned CHECK_POS = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;   // a received word is accepted this cycle
        logic emit;   // the stored sentence is being played out
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close;      // the accepted word closes a valid frame
        logic last_load;  // the closing asterisk moves to the output register
    } t_dp_status;

endpackage

>>> design/ngsf_datapath.sv
module ngsf_datapath #(
    parameter int unsigned MAX_SENTENCE = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ngsf_pkg::t_ctl_cmd    i_cmd,
    output ngsf_pkg::t_dp_status  o_status,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [7:0]            o_sentence_byte,
    output logic                  o_last
);

    localparam int unsigned CW = $clog2(MAX_SENTENCE + 1);
    localparam int unsigned AW = $clog2(MAX_SENTENCE);
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_SENTENCE);
    localparam logic [CW-1:0] MAXM1_C = CW'(MAX_SENTENCE - 1);
    localparam logic [CW-1:0] CHK_C   = CW'(ngsf_pkg::CHECK_POS);

    logic [7:0]    r_mem [MAX_SENTENCE];
    logic [CW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] r_end_ptr;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic is_star, store_ok, drop, store, close, write_en, load, load_last;

    always_comb begin
        is_star  = (i_rx_byte == ngsf_pkg::CH_STAR);
        store_ok = i_cmd.take &&
                   ((!is_star && (r_fill != '0) && (r_fill < MAX_C)) ||
                    ((i_rx_byte == ngsf_pkg::CH_DOLLAR) && (r_fill == '0)));
        drop     = store_ok && (r_fill == CHK_C) && (i_rx_byte != ngsf_pkg::CH_L);
        store    = store_ok && !drop;
        close    = i_cmd.take && !store_ok && is_star &&
                   (r_fill != '0) && (r_fill < MAXM1_C);
        write_en = store || close;
        if (i_cmd.take) begin
            n_fill = store ? (r_fill + CW'(1)) : '0;
        end else begin
            n_fill = r_fill;
        end
        load      = i_cmd.emit && (!r_out_valid || !i_out_stall);
        load_last = load && (r_rd_ptr == r_end_ptr);
    end

    // Capture memory: one write port, one registered read into the output word.
    always_ff @(posedge i_clk) begin
        if (write_en) begin
            r_mem[r_fill[AW-1:0]] <= i_rx_byte;
        end
        if (load) begin
            r_out_byte <= r_mem[r_rd_ptr];
            r_out_last <= load_last;
        end
        if (close) begin
            r_end_ptr <= r_fill[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (close) begin
                r_rd_ptr <= '0;
            end else if (load) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.close     = close;
    assign o_status.last_load = load_last;
    assign o_out_valid        = r_out_valid;
    assign o_sentence_byte    = r_out_byte;
    assign o_last             = r_out_last;

endmodule

>>> design/ngsf_controller.sv
module ngsf_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rx_valid,
    output logic                  o_rx_stall,
    output ngsf_pkg::t_ctl_cmd    o_cmd,
    input  ngsf_pkg::t_dp_status  i_status
);

    localparam logic ST_CAPTURE = 1'b0;
    localparam logic ST_EMIT    = 1'b1;

    logic r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_rx_stall = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_CAPTURE: begin
                o_cmd.take = i_rx_valid;
                if (i_status.close) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_rx_stall = 1'b1;
                o_cmd.emit = 1'b1;
                if (i_status.last_load) begin
                    n_state = ST_CAPTURE;
                end
            end
            default: begin
                n_state = ST_CAPTURE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CAPTURE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/nmea_gll_sentence_framer_top.sv
// GLL sentence framer. Received serial bytes enter one word at a time on the rx
// channel. While no frame is open only a dollar sign opens one; each later byte
// is stored, and the frame is dropped silently if the byte at position 4 is not
// 'L', if it overruns MAX_SENTENCE bytes, or if an asterisk comes too late. An
// asterisk at a position from 1 to MAX_SENTENCE-2 closes the frame, and the
// whole sentence from the dollar sign through the asterisk is then played out
// on the output channel, one word per byte, with o_last set on the asterisk.
// Timing: while a frame is being captured the block takes one word every
// cycle. After the closing asterisk the rx channel is stalled while the
// sentence is read out of the capture memory through its single read port,
// one byte per cycle while the output side does not stall. Once the asterisk
// is in the output register the block accepts input again, even if that word
// has not yet been taken.

module nmea_gll_sentence_framer_top #(
    parameter int unsigned MAX_SENTENCE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Received byte channel.
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    // Sentence output channel.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_sentence_byte,
    output logic       o_last
);

    // Commands and status between the controller and the datapath.
    ngsf_pkg::t_ctl_cmd   cmd;
    ngsf_pkg::t_dp_status status;

    // The controller decides whether the block is capturing or playing out.
    ngsf_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // The datapath holds the capture memory, the fill count and the output word.
    ngsf_datapath #(
        .MAX_SENTENCE (MAX_SENTENCE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_rx_byte       (i_rx_byte),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_sentence_byte (o_sentence_byte),
        .o_last          (o_last)
    );

endmodule

>>> design/ngsf_checker.sv
`include "nmea_gll_sentence_framer_top_defines.svh"

module ngsf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_valid,
    input logic       o_rx_stall,
    input logic [7:0] i_rx_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_sentence_byte,
    input logic       o_last
);

    // A stalled output word holds.
    `NGSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_sentence_byte) && $stable(o_last), "output word changed while stalled")

    // The final word of every sentence is the asterisk.
    `NGSF_ASSERT_SAME(a_last_star, i_clk, i_rst_n, o_out_valid && o_last, o_sentence_byte == ngsf_pkg::CH_STAR, "last word is not an asterisk")

    // Mid-sentence the input side stays stalled.
    `NGSF_ASSERT_SAME(a_busy_stall, i_clk, i_rst_n, o_out_valid && !o_last, o_rx_stall, "input taken during sentence playout")

    // The word after a finished sentence starts a new one with a dollar sign.
    `NGSF_ASSERT_NEXT(a_first_dollar, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_last, !o_out_valid || (o_sentence_byte == ngsf_pkg::CH_DOLLAR), "sentence does not start with a dollar sign")

endmodule

bind nmea_gll_sentence_framer_top ngsf_checker u_ngsf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rx_valid      (i_rx_valid),
    .o_rx_stall      (o_rx_stall),
    .i_rx_byte       (i_rx_byte),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_sentence_byte (o_sentence_byte),
    .o_last          (o_last)
);

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Capture memory depth of the block under test.
    localparam int unsigned MAX_SENTENCE = 64;
    // Received words that should do something (open, fill or close a frame)
    // in the random part. Words that the block ignores while idle do not count.
    localparam int RANDOM_WORDS = 410;
    // The receiver's long hold-off, which lets the block fill up and stall rx.
    localparam int HOLD_CYCLES = 300;
    // Quiet time after the last expected word. The longest sentence has
    // 63 words, so this covers any late word.
    localparam int TAIL_CYCLES = 100;
    // The slowest correct run stays far below this.
    localparam int LIMIT_CYCLES = 400000;

    // One word of a completed sentence.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_sentence_word;

    // One row of the directed part. A row sends its text, or the raw byte
    // when the text is empty. A word count of zero or more makes the row a
    // checkpoint: the run drains the block and compares the number of
    // sentence words that came out since the last checkpoint. Fields are
    // always checked against the predictor.
    typedef struct {
        logic [7:0] raw;
        string      text;
        int         exp_words;
    } t_probe_row;

    localparam int N_PROBES = 8;

    t_probe_row probe_rows [N_PROBES] = '{
        // A byte other than a dollar sign while idle is ignored.
        '{8'h00, "", 0},
        // An asterisk while idle is ignored too.
        '{8'h00, "*", 0},
        // The shortest sentence: an asterisk right after the dollar sign.
        '{8'h00, "$*", 2},
        // A dollar sign inside a frame is stored like any other byte, and an
        // asterisk at position 4 closes the frame without the 'L' test.
        '{8'h00, "$AB$*", 5},
        // Position 4 is not 'L', so the frame is dropped.
        '{8'h00, "$GPGX", 0},
        // A GLL frame that carries both extreme byte values.
        '{8'h00, "$GPGL", -1},
        '{8'h00, "", -1},
        '{8'h00, "\377*", 8}
    };

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_rx_valid = 1'b0;
    logic       o_rx_stall;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_sentence_byte;
    logic       o_last;

    nmea_gll_sentence_framer_top #(
        .MAX_SENTENCE(MAX_SENTENCE)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sentence_byte(o_sentence_byte),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Predictor state: the open frame and how many bytes it holds.
    logic [7:0]     frame_mem [MAX_SENTENCE];
    int unsigned    frame_len = 0;
    // Sentence words that the block still owes, oldest first.
    t_sentence_word sentence_q [$];
    t_sentence_word head_word;

    int fail_count   = 0;
    int useful_words = 0;
    int words_out    = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    bit hold_wanted  = 1'b0;
    bit hold_done    = 1'b0;

    // Advances the frame by one received byte and queues the sentence when
    // the byte closes it. Returns 0 for a byte that the idle block ignores.
    function automatic bit frame_byte(input logic [7:0] ch);
        int unsigned    n;
        int unsigned    k;
        t_sentence_word w;
        n = frame_len;
        if ((ch != ngsf_pkg::CH_STAR && n > 0 && n < MAX_SENTENCE) ||
            (ch == ngsf_pkg::CH_DOLLAR && n == 0)) begin
            if (n == ngsf_pkg::CHECK_POS && ch != ngsf_pkg::CH_L) begin
                frame_len = 0;
            end else begin
                frame_mem[n] = ch;
                frame_len = n + 1;
            end
            return 1'b1;
        end
        if (ch == ngsf_pkg::CH_STAR && n > 0 && n < MAX_SENTENCE - 1) begin
            frame_mem[n] = ch;
            for (k = 0; k <= n; k++) begin
                w.ch = frame_mem[k];
                w.last = (k == n);
                sentence_q.push_back(w);
            end
            frame_len = 0;
            return 1'b1;
        end
        // Overruns and late asterisks drop the frame; an idle block simply
        // ignores the byte.
        frame_len = 0;
        return (n != 0);
    endfunction

    // Both channels are sampled at the clock edge, before the block's own
    // updates from that edge land, so the view is free of ordering races.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rx_valid && !o_rx_stall) begin
                if (frame_byte(i_rx_byte)) useful_words++;
            end
            if (o_out_valid && !i_out_stall) begin
                words_out++;
                if (sentence_q.size() == 0) begin
                    $error("unexpected sentence word: sentence_byte %h, last %b",
                           o_sentence_byte, o_last);
                    fail_count++;
                end else begin
                    head_word = sentence_q.pop_front();
                    if (o_sentence_byte !== head_word.ch) begin
                        $error("sentence_byte: expected %h, actual %h",
                               head_word.ch, o_sentence_byte);
                        fail_count++;
                    end
                    if (o_last !== head_word.last) begin
                        $error("last: expected %b, actual %b", head_word.last, o_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Offers one received word and returns at the edge that accepts it. The
    // sender works in bursts; between bursts valid drops for a random gap,
    // and some bursts follow each other with no gap at all.
    task automatic send_word(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 60);
            if (gap != 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_rx_stall);
    endtask

    // Drops valid and waits until every expected sentence word has come out.
    // The first edge lets the monitor book the last accepted word.
    task automatic drain_sentences();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (sentence_q.size() != 0) @(posedge i_clk);
    endtask

    // A random payload byte that never closes a frame, and optionally never
    // passes the 'L' test either.
    function automatic logic [7:0] body_byte(input bit avoid_l);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == ngsf_pkg::CH_STAR || (avoid_l && b == ngsf_pkg::CH_L));
        return b;
    endfunction

    // Sends a dollar sign, body_len payload bytes and, if asked, the closing
    // asterisk. With good_l the byte at the check position is 'L'.
    task automatic send_frame(input int body_len, input bit good_l, input bit close);
        int i;
        send_word(ngsf_pkg::CH_DOLLAR);
        for (i = 1; i <= body_len; i++) begin
            if (i == ngsf_pkg::CHECK_POS) send_word(good_l ? ngsf_pkg::CH_L : body_byte(1'b1));
            else send_word(body_byte(1'b0));
        end
        if (close) send_word(ngsf_pkg::CH_STAR);
    endtask

    // Receiver. It stalls in segments of its own: none, light, heavy,
    // alternating, and now and then a long hold. Once the random part starts
    // it holds off for HOLD_CYCLES while the sender keeps offering, so the
    // block fills up and must stall its input.
    initial begin : out_side
        int seg;
        int mode;
        int k;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_wanted && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 9);
                seg = $urandom_range(10, 120);
                for (k = 0; k < seg; k++) begin
                    case (mode)
                        0, 1, 2: i_out_stall <= 1'b0;
                        3, 4:    i_out_stall <= ($urandom_range(0, 3) == 0);
                        5, 6:    i_out_stall <= ($urandom_range(0, 3) != 0);
                        7, 8:    i_out_stall <= k[0];
                        default: i_out_stall <= 1'b1;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: a run that stops making progress ends here.
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus: reset, the directed rows, then random frames.
    initial begin : rx_side
        int r;
        int i;
        int mark;
        int pick;
        int base;
        mark = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < N_PROBES; r++) begin
            if (probe_rows[r].text.len() == 0) begin
                send_word(probe_rows[r].raw);
            end else begin
                for (i = 0; i < probe_rows[r].text.len(); i++) send_word(probe_rows[r].text[i]);
            end
            if (probe_rows[r].exp_words >= 0) begin
                drain_sentences();
                if (words_out - mark != probe_rows[r].exp_words) begin
                    $error("sentence words in row %0d: expected %0d, actual %0d",
                           r, probe_rows[r].exp_words, words_out - mark);
                    fail_count++;
                end
                mark = words_out;
            end
        end

        // Random part. Most traffic is well-formed GLL frames with random
        // content; the rest is idle noise, failed 'L' tests, short frames,
        // frames at and past the length limit, and frames left open, whose
        // bytes run on into the next frame as ordinary content.
        hold_wanted = 1'b1;
        base = useful_words;
        while (useful_words - base < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                if ($urandom_range(0, 7) == 0) send_frame($urandom_range(21, 61), 1'b1, 1'b1);
                else send_frame($urandom_range(4, 20), 1'b1, 1'b1);
            end else if (pick < 70) begin
                // Idle noise: mostly ignored, and a stray asterisk now and then.
                for (i = 0; i < $urandom_range(1, 4); i++) begin
                    if ($urandom_range(0, 3) == 0) send_word(ngsf_pkg::CH_STAR);
                    else send_word(8'($urandom_range(0, 255)));
                end
            end else if (pick < 77) begin
                send_frame($urandom_range(4, 10), 1'b0, 1'b1);
            end else if (pick < 84) begin
                send_frame($urandom_range(0, 3), 1'b1, 1'b1);
            end else if (pick < 88) begin
                // Longest sentence that still closes.
                send_frame(MAX_SENTENCE - 3, 1'b1, 1'b1);
            end else if (pick < 93) begin
                // Asterisk one too late, at the full store, or a full overrun.
                send_frame($urandom_range(MAX_SENTENCE - 2, MAX_SENTENCE), 1'b1, 1'b1);
            end else begin
                send_frame($urandom_range(1, 12), 1'b1, 1'b0);
            end
        end

        drain_sentences();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sentence_q.size() != 0) begin
            $error("%0d sentence words never arrived", sentence_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
